// ----- hw/rtl/double_to_hex_float_text_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the hex float text formatter
// Shared concurrent assertion forms, clocked and disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_TO_HEX_FLOAT_TEXT_DEFINES_SVH
`define DOUBLE_TO_HEX_FLOAT_TEXT_DEFINES_SVH

// Same-cycle implication: the consequent must hold whenever the antecedent does.
`define DHF_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication: the consequent must hold in the cycle after the antecedent.
`define DHF_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/dhf_pkg.sv -----
// ----------------------------------------------------------------------------
// dhf_pkg
// Types, constants and helpers shared by the hex float text formatter.
// ----------------------------------------------------------------------------
package dhf_pkg;

    // Field geometry of an IEEE 754 double.
    localparam int FRAC_W      = 52;
    localparam int EXP_W       = 11;
    localparam int FRAC_DIGITS = 13;
    localparam int CHAR_W      = 7;

    localparam logic [EXP_W-1:0] EXP_BIAS   = 11'h3ff;
    localparam logic [EXP_W-1:0] DENORM_EXP = EXP_BIAS - 11'd1;

    // ASCII codes used in the text.
    localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2d;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 7'h2b;
    localparam logic [CHAR_W-1:0] CH_DOT   = 7'h2e;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] CH_ONE   = 7'h31;
    localparam logic [CHAR_W-1:0] CH_NINE  = 7'h39;
    localparam logic [CHAR_W-1:0] CH_LOW_A = 7'h61;
    localparam logic [CHAR_W-1:0] CH_P     = 7'h70;
    localparam logic [CHAR_W-1:0] CH_X     = 7'h78;

    // Decoded value after the first stage.
    typedef struct packed {
        logic              neg;
        logic              lead_zero;
        logic [FRAC_W-1:0] frac;
        logic              exp_neg;
        logic [EXP_W-1:0]  mag;
    } t_dec;

    // Partly converted exponent after the second stage.
    typedef struct packed {
        logic              neg;
        logic              lead_zero;
        logic [FRAC_W-1:0] frac;
        logic              exp_neg;
        logic              thou;
        logic [3:0]        hund;
        logic [6:0]        rem;
        logic [1:0]        dec_top;
    } t_mid;

    // Everything the character sequencer needs for one value.
    typedef struct packed {
        logic              neg;
        logic              lead_zero;
        logic [FRAC_W-1:0] frac;
        logic              exp_neg;
        logic              has_frac;
        logic [3:0]        frac_last;
        logic [3:0][3:0]   dec;
        logic [1:0]        dec_top;
    } t_item;

    // Character sequencer states: each names the next character to produce.
    typedef enum logic [3:0] {
        S_IDLE,
        S_MINUS,
        S_ZERO,
        S_X,
        S_LEAD,
        S_DOT,
        S_FRAC,
        S_P,
        S_ESIGN,
        S_EDIG
    } t_emit_state;

    // Lower-case hexadecimal digit character.
    function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] d);
        logic [CHAR_W-1:0] c;
        if (d < 4'd10) begin
            c = CH_ZERO + {3'b000, d};
        end else begin
            c = CH_LOW_A + {3'b000, d} - 7'd10;
        end
        return c;
    endfunction

endpackage

// ----- hw/rtl/dhf_decode.sv -----
// ----------------------------------------------------------------------------
// dhf_decode
// First pipeline stage: splits the double and forms the exponent sign and
// magnitude, covering zero, denormal and normal encodings.
// ----------------------------------------------------------------------------
module dhf_decode (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [63:0]   i_value_bits,
    output logic          o_valid,
    input  logic          i_ready,
    output dhf_pkg::t_dec o_dec
);

    logic [dhf_pkg::EXP_W-1:0]  field;
    logic [dhf_pkg::FRAC_W-1:0] frac;
    dhf_pkg::t_dec              n_dec;
    dhf_pkg::t_dec              r_dec;
    logic                       r_valid;

    assign field = i_value_bits[62:52];
    assign frac  = i_value_bits[dhf_pkg::FRAC_W-1:0];

    // Exponent sign and magnitude for each class of encoding.
    always_comb begin
        n_dec.neg       = i_value_bits[63];
        n_dec.lead_zero = (field == '0);
        n_dec.frac      = frac;
        priority if (field == '0) begin
            n_dec.exp_neg = (frac != '0);
            n_dec.mag     = (frac != '0) ? dhf_pkg::DENORM_EXP : '0;
        end else if (field >= dhf_pkg::EXP_BIAS) begin
            n_dec.exp_neg = 1'b0;
            n_dec.mag     = field - dhf_pkg::EXP_BIAS;
        end else begin
            n_dec.exp_neg = 1'b1;
            n_dec.mag     = dhf_pkg::EXP_BIAS - field;
        end
    end

    // Stage handshake: the register takes a beat whenever it is empty or drains.
    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_dec <= n_dec;
        end
    end

    assign o_valid = r_valid;
    assign o_dec   = r_dec;

endmodule

// ----- hw/rtl/dhf_digits.sv -----
// ----------------------------------------------------------------------------
// dhf_digits
// Second and third pipeline stages: converts the exponent magnitude to
// decimal digits by reciprocal multiplication and finds the last non-zero
// fraction digit.
// ----------------------------------------------------------------------------
`include "double_to_hex_float_text_defines.svh"

module dhf_digits (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  dhf_pkg::t_dec  i_dec,
    output logic           o_valid,
    input  logic           i_ready,
    output dhf_pkg::t_item o_item
);

    dhf_pkg::t_mid  n_b;
    dhf_pkg::t_mid  r_b;
    logic           r_b_valid;
    logic           ready_b;
    dhf_pkg::t_item n_c;
    dhf_pkg::t_item r_c;
    logic           r_c_valid;
    logic           ready_c;

    logic [9:0]     below_k;
    logic [15:0]    prod_h;
    logic [9:0]     sub_h;
    logic [14:0]    prod_t;
    logic [3:0]     tens;
    logic [6:0]     units;
    logic [dhf_pkg::FRAC_DIGITS-1:0][3:0] nibs;
    logic [3:0]     frac_last;

    // Thousands and hundreds; x*41>>12 equals x/100 for x below 1000.
    always_comb begin
        n_b.neg       = i_dec.neg;
        n_b.lead_zero = i_dec.lead_zero;
        n_b.frac      = i_dec.frac;
        n_b.exp_neg   = i_dec.exp_neg;
        n_b.thou      = (i_dec.mag >= 11'd1000);
        below_k       = n_b.thou ? 10'(i_dec.mag - 11'd1000) : i_dec.mag[9:0];
        prod_h        = {6'd0, below_k} * 16'd41;
        n_b.hund      = prod_h[15:12];
        sub_h         = below_k - ({6'd0, n_b.hund} * 10'd100);
        n_b.rem       = sub_h[6:0];
        priority if (i_dec.mag >= 11'd1000) begin
            n_b.dec_top = 2'd3;
        end else if (i_dec.mag >= 11'd100) begin
            n_b.dec_top = 2'd2;
        end else if (i_dec.mag >= 11'd10) begin
            n_b.dec_top = 2'd1;
        end else begin
            n_b.dec_top = 2'd0;
        end
    end

    // Tens and units; x*205>>11 equals x/10 for x below 100.
    always_comb begin
        prod_t = {8'd0, r_b.rem} * 15'd205;
        tens   = prod_t[14:11];
        units  = r_b.rem - ({3'd0, tens} * 7'd10);
    end

    // Position of the last non-zero fraction digit, most significant first.
    always_comb begin
        nibs      = r_b.frac;
        frac_last = '0;
        for (int i = 0; i < dhf_pkg::FRAC_DIGITS; i++) begin
            if (nibs[dhf_pkg::FRAC_DIGITS-1-i] != 4'd0) begin
                frac_last = 4'(i);
            end
        end
    end

    always_comb begin
        n_c.neg       = r_b.neg;
        n_c.lead_zero = r_b.lead_zero;
        n_c.frac      = r_b.frac;
        n_c.exp_neg   = r_b.exp_neg;
        n_c.has_frac  = (r_b.frac != '0);
        n_c.frac_last = frac_last;
        n_c.dec[3]    = {3'd0, r_b.thou};
        n_c.dec[2]    = r_b.hund;
        n_c.dec[1]    = tens;
        n_c.dec[0]    = units[3:0];
        n_c.dec_top   = r_b.dec_top;
    end

    // Handshake for both stages: each takes a beat when empty or draining.
    assign ready_c = !r_c_valid || i_ready;
    assign ready_b = !r_b_valid || ready_c;
    assign o_ready = ready_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else begin
            if (ready_b) begin
                r_b_valid <= i_valid;
            end
            if (ready_c) begin
                r_c_valid <= r_b_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready_b && i_valid) begin
            r_b <= n_b;
        end
        if (ready_c && r_b_valid) begin
            r_c <= n_c;
        end
    end

    assign o_valid = r_c_valid;
    assign o_item  = r_c;

    // The remainder below a hundred must fit two decimal digits.
    `DHF_ASSERT_IMP(a_rem_below_hundred, i_clk, i_rst_n, r_b_valid, r_b.rem < 7'd100, "remainder out of range")
    // Every decimal digit handed on is a real digit.
    `DHF_ASSERT_IMP(a_dec_digits, i_clk, i_rst_n, r_c_valid, r_c.dec[0] <= 4'd9 && r_c.dec[1] <= 4'd9 && r_c.dec[2] <= 4'd9 && r_c.dec[3] <= 4'd1, "decimal digit out of range")
    // A short exponent has no thousands digit.
    `DHF_ASSERT_IMP(a_no_thousands, i_clk, i_rst_n, r_c_valid && r_c.dec_top != 2'd3, r_c.dec[3] == 4'd0, "stray thousands digit")

endmodule

// ----- hw/rtl/dhf_emit.sv -----
// ----------------------------------------------------------------------------
// dhf_emit
// Character sequencer: walks one decoded value through its text, one
// character per beat, into an output register that parts it from the sink.
// ----------------------------------------------------------------------------
`include "double_to_hex_float_text_defines.svh"

module dhf_emit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  dhf_pkg::t_item               i_item,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [dhf_pkg::CHAR_W-1:0]   o_text_char,
    output logic                         o_last_char
);

    dhf_pkg::t_emit_state              r_state;
    dhf_pkg::t_emit_state              n_state;
    dhf_pkg::t_item                    r_item;
    logic [3:0]                        r_frac_idx;
    logic [3:0]                        n_frac_idx;
    logic [1:0]                        r_dig_idx;
    logic [1:0]                        n_dig_idx;
    logic                              r_out_valid;
    logic [dhf_pkg::CHAR_W-1:0]        r_out_char;
    logic                              r_out_last;

    logic                              advance;
    logic                              item_done;
    logic                              take;
    logic [dhf_pkg::CHAR_W-1:0]        cur_char;
    logic                              cur_last;
    logic [dhf_pkg::FRAC_DIGITS-1:0][3:0] nibs;

    // A character is produced whenever a value is held and the output slot frees.
    assign advance   = (r_state != dhf_pkg::S_IDLE) && (!r_out_valid || i_ready);
    assign item_done = advance && (r_state == dhf_pkg::S_EDIG) && (r_dig_idx == 2'd0);
    assign o_ready   = (r_state == dhf_pkg::S_IDLE) || item_done;
    assign take      = i_valid && o_ready;

    // Next state and position counters.
    always_comb begin
        n_state    = r_state;
        n_frac_idx = r_frac_idx;
        n_dig_idx  = r_dig_idx;
        if (advance) begin
            unique case (r_state)
                dhf_pkg::S_IDLE:  n_state = dhf_pkg::S_IDLE;
                dhf_pkg::S_MINUS: n_state = dhf_pkg::S_ZERO;
                dhf_pkg::S_ZERO:  n_state = dhf_pkg::S_X;
                dhf_pkg::S_X:     n_state = dhf_pkg::S_LEAD;
                dhf_pkg::S_LEAD: begin
                    n_state = r_item.has_frac ? dhf_pkg::S_DOT : dhf_pkg::S_P;
                end
                dhf_pkg::S_DOT: begin
                    n_state    = dhf_pkg::S_FRAC;
                    n_frac_idx = 4'd0;
                end
                dhf_pkg::S_FRAC: begin
                    if (r_frac_idx == r_item.frac_last) begin
                        n_state = dhf_pkg::S_P;
                    end else begin
                        n_frac_idx = r_frac_idx + 4'd1;
                    end
                end
                dhf_pkg::S_P:     n_state = dhf_pkg::S_ESIGN;
                dhf_pkg::S_ESIGN: begin
                    n_state   = dhf_pkg::S_EDIG;
                    n_dig_idx = r_item.dec_top;
                end
                dhf_pkg::S_EDIG: begin
                    if (r_dig_idx == 2'd0) begin
                        n_state = dhf_pkg::S_IDLE;
                    end else begin
                        n_dig_idx = r_dig_idx - 2'd1;
                    end
                end
                default: n_state = dhf_pkg::S_IDLE;
            endcase
        end
        // A new value starts as the previous one finishes or from idle.
        if (take) begin
            n_state = i_item.neg ? dhf_pkg::S_MINUS : dhf_pkg::S_ZERO;
        end
    end

    // Character for the current state.
    always_comb begin
        nibs     = r_item.frac;
        cur_last = 1'b0;
        unique case (r_state)
            dhf_pkg::S_IDLE:  cur_char = dhf_pkg::CH_ZERO;
            dhf_pkg::S_MINUS: cur_char = dhf_pkg::CH_MINUS;
            dhf_pkg::S_ZERO:  cur_char = dhf_pkg::CH_ZERO;
            dhf_pkg::S_X:     cur_char = dhf_pkg::CH_X;
            dhf_pkg::S_LEAD: begin
                cur_char = r_item.lead_zero ? dhf_pkg::CH_ZERO : dhf_pkg::CH_ONE;
            end
            dhf_pkg::S_DOT:   cur_char = dhf_pkg::CH_DOT;
            dhf_pkg::S_FRAC: begin
                cur_char = dhf_pkg::hex_char(nibs[4'(dhf_pkg::FRAC_DIGITS - 1) - r_frac_idx]);
            end
            dhf_pkg::S_P:     cur_char = dhf_pkg::CH_P;
            dhf_pkg::S_ESIGN: begin
                cur_char = r_item.exp_neg ? dhf_pkg::CH_MINUS : dhf_pkg::CH_PLUS;
            end
            dhf_pkg::S_EDIG: begin
                cur_char = dhf_pkg::CH_ZERO + {3'b000, r_item.dec[r_dig_idx]};
                cur_last = (r_dig_idx == 2'd0);
            end
            default:          cur_char = dhf_pkg::CH_ZERO;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dhf_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (!r_out_valid || i_ready) begin
                r_out_valid <= advance;
            end
        end
    end

    // Held value, counters and output beat.
    always_ff @(posedge i_clk) begin
        r_frac_idx <= n_frac_idx;
        r_dig_idx  <= n_dig_idx;
        if (take) begin
            r_item <= i_item;
        end
        if (advance) begin
            r_out_char <= cur_char;
            r_out_last <= cur_last;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_text_char = r_out_char;
    assign o_last_char = r_out_last;

    // Every text opens with a sign or the zero of the prefix.
    `DHF_ASSERT_NXT(a_start_state, i_clk, i_rst_n, take, r_state == dhf_pkg::S_MINUS || r_state == dhf_pkg::S_ZERO, "bad start state")
    // The fraction walk never passes the last non-zero digit.
    `DHF_ASSERT_IMP(a_frac_bound, i_clk, i_rst_n, r_state == dhf_pkg::S_FRAC, r_frac_idx <= r_item.frac_last, "fraction index overrun")
    // The final character of a text is always a decimal digit.
    `DHF_ASSERT_IMP(a_last_digit, i_clk, i_rst_n, r_out_valid && r_out_last, r_out_char >= dhf_pkg::CH_ZERO && r_out_char <= dhf_pkg::CH_NINE, "last character not a digit")
    // The exponent walk stays within the digits present.
    `DHF_ASSERT_IMP(a_dig_bound, i_clk, i_rst_n, r_state == dhf_pkg::S_EDIG, r_dig_idx <= r_item.dec_top, "exponent digit index overrun")

endmodule

// ----- hw/rtl/double_to_hex_float_text.sv -----
// ----------------------------------------------------------------------------
// double_to_hex_float_text
// Formats a raw IEEE 754 double as hexadecimal floating-point text, one
// ASCII character per output beat, with a flag on the final character.
//
//   Channel  Direction  Handshake          Payload
//   value    in         i_valid, o_ready   i_value_bits[63:0]
//   text     out        o_valid, i_ready   o_text_char[6:0], o_last_char
//
// A value passes three register stages (decode, hundreds, tens and digit
// scan) and reaches the character sequencer, whose output register
// presents its first character to the sink.
// Each value then occupies the sequencer, one character per cycle while the
// sink is ready, so the output port sets the rate; the next value is taken in
// the cycle that produces the last character of the previous one.
// Reset clears all valid bits and the sequencer; a stall holds every stage.
// ----------------------------------------------------------------------------
module double_to_hex_float_text (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [63:0] i_value_bits,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [6:0]  o_text_char,
    output logic        o_last_char
);

    dhf_pkg::t_dec  dec_bus;
    logic           dec_valid;
    logic           dec_ready;
    dhf_pkg::t_item item_bus;
    logic           item_valid;
    logic           item_ready;

    // Field split and exponent magnitude.
    dhf_decode u_decode (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_value_bits (i_value_bits),
        .o_valid      (dec_valid),
        .i_ready      (dec_ready),
        .o_dec        (dec_bus)
    );

    // Decimal exponent digits and fraction length.
    dhf_digits u_digits (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (dec_valid),
        .o_ready (dec_ready),
        .i_dec   (dec_bus),
        .o_valid (item_valid),
        .i_ready (item_ready),
        .o_item  (item_bus)
    );

    // Character sequencer and output register.
    dhf_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (item_valid),
        .o_ready     (item_ready),
        .i_item      (item_bus),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_text_char (o_text_char),
        .o_last_char (o_last_char)
    );

endmodule
